// File: rtl/olt_pkg.sv
// Shared constants, request codes and types of the open-handle LRU table.
package olt_pkg;

    localparam int ENTRIES    = 8;
    localparam int KEY_BITS   = 32;
    localparam int STAMP_BITS = 32;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_BITS  = 3;
    localparam int FKEY_BITS  = 32;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [STAMP_BITS-1:0] STAMP_NEVER   = STAMP_BITS'(0);
    localparam logic [STAMP_BITS-1:0] STAMP_FLUSHED = STAMP_BITS'(1);
    localparam logic [STAMP_BITS-1:0] COUNTER_START = STAMP_BITS'(2);
    localparam logic [STAMP_BITS-1:0] COUNTER_MAX   = '1;

    localparam logic [1:0] REQ_ACCESS    = 2'd0;
    localparam logic [1:0] REQ_FLUSH_ONE = 2'd1;
    localparam logic [1:0] REQ_FLUSH_ALL = 2'd2;

    typedef enum logic [1:0] {
        SLOT_NEVER,
        SLOT_FLUSHED,
        SLOT_USED
    } t_slot_st;

    typedef struct packed {
        logic                  key_we;
        logic                  stamp_we;
        logic                  flush_one;
        logic                  flush_all;
        logic [IDX_W-1:0]      idx;
        logic [KEY_BITS-1:0]   key;
        logic [STAMP_BITS-1:0] stamp;
    } t_wr_req;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [STAMP_BITS-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [IDX_W-1:0]      min_idx;
        logic                  min_valid;
        logic [KEY_BITS-1:0]   min_key;
    } t_scan_res;

endpackage

// File: rtl/open_handle_lru_table_top.sv
// Top level of the open-handle LRU table: request sequencer, recency counter and result register.
// Access and flush-one requests read every slot from the memories, one slot per cycle, in S_SCAN, then
// pass through S_DRAIN to the write-back in S_FIN; flush-all and unknown requests go straight to S_FIN.
// A request is taken only in S_IDLE, so the next one waits until the last has been written back in S_FIN,
// which itself waits while the output register still holds an unaccepted result.
// A finished result waits in the output register while the next request is taken.
// Reset clears all slot status to never used and loads the access counter with two.
module open_handle_lru_table_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // file_key [31:0], open_ok [32], zero padding [39:33]
    input  logic [olt_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // req_type [1:0]
    input  logic [olt_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // hit [0], slot [3:1], replaced_valid [4], replaced_key [36:5], forwarded [37],
    // found [38], zero padding [39]
    output logic [olt_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state                           r_state, n_state;
    logic [1:0]                       r_req;
    logic [olt_pkg::KEY_BITS-1:0]     r_key;
    logic                             r_open_ok;
    logic [olt_pkg::IDX_W-1:0]        r_rd_idx, n_rd_idx;
    logic                             r_dvld;
    logic [olt_pkg::IDX_W-1:0]        r_didx;
    logic [olt_pkg::STAMP_BITS-1:0]   r_use_cnt, n_use_cnt;
    logic                             r_out_valid, n_out_valid;
    logic [olt_pkg::OUT_DATA_W-1:0]   r_out_data, n_out_data;

    logic                             in_acc;
    logic                             rd_en;
    logic                             fin_go;
    olt_pkg::t_wr_req                 wr;
    olt_pkg::t_entry                  entry;
    olt_pkg::t_scan_res               res;

    logic                             res_hit;
    logic [olt_pkg::IDX_W-1:0]        res_slot;
    logic                             res_rvalid;
    logic [olt_pkg::KEY_BITS-1:0]     res_rkey;
    logic                             res_fwd;
    logic                             res_found;
    logic                             take;

    olt_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (rd_en),
        .i_rd_idx (r_rd_idx),
        .i_wr     (wr),
        .o_entry  (entry)
    );

    olt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_dvld),
        .i_first (r_didx == '0),
        .i_idx   (r_didx),
        .i_entry (entry),
        .i_key   (r_key),
        .o_res   (res)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign rd_en      = (r_state == S_SCAN);
    assign fin_go     = (r_state == S_FIN) && (!r_out_valid || i_m_tready);

    // Decide the outcome of the request from the scan result and build the write-back.
    always_comb begin
        wr         = '0;
        wr.key     = r_key;
        wr.stamp   = r_use_cnt;
        res_hit    = 1'b0;
        res_slot   = '0;
        res_rvalid = 1'b0;
        res_rkey   = '0;
        res_fwd    = 1'b0;
        res_found  = 1'b0;
        take       = 1'b0;
        unique case (r_req)
            olt_pkg::REQ_ACCESS: begin
                if (res.hit) begin
                    res_hit     = 1'b1;
                    res_slot    = res.hit_idx;
                    wr.idx      = res.hit_idx;
                    wr.stamp_we = fin_go;
                    take        = 1'b1;
                end else if (r_open_ok) begin
                    res_slot    = res.min_idx;
                    res_rvalid  = res.min_valid;
                    res_rkey    = res.min_valid ? res.min_key : '0;
                    wr.idx      = res.min_idx;
                    wr.key_we   = fin_go;
                    wr.stamp_we = fin_go;
                    take        = 1'b1;
                end else begin
                    res_fwd = 1'b1;
                end
            end
            olt_pkg::REQ_FLUSH_ONE: begin
                if (res.hit) begin
                    res_found    = 1'b1;
                    res_slot     = res.hit_idx;
                    wr.idx       = res.hit_idx;
                    wr.flush_one = fin_go;
                end
            end
            olt_pkg::REQ_FLUSH_ALL: begin
                wr.flush_all = fin_go;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_use_cnt   = r_use_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rd_idx = '0;
                    if (i_s_tuser == olt_pkg::REQ_ACCESS ||
                        i_s_tuser == olt_pkg::REQ_FLUSH_ONE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                n_rd_idx = r_rd_idx + 1'b1;
                if (r_rd_idx == olt_pkg::IDX_W'(olt_pkg::ENTRIES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, res_found, res_fwd, olt_pkg::FKEY_BITS'(res_rkey),
                                   res_rvalid, olt_pkg::SLOT_BITS'(res_slot), res_hit};
                    if (take && r_use_cnt != olt_pkg::COUNTER_MAX) begin
                        n_use_cnt = r_use_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_dvld      <= 1'b0;
            r_didx      <= '0;
            r_use_cnt   <= olt_pkg::COUNTER_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_dvld      <= rd_en;
            r_didx      <= r_rd_idx;
            r_use_cnt   <= n_use_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (in_acc) begin
            r_req     <= i_s_tuser;
            r_key     <= olt_pkg::KEY_BITS'(i_s_tdata[olt_pkg::FKEY_BITS-1:0]);
            r_open_ok <= i_s_tdata[olt_pkg::FKEY_BITS];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // The write-back never overlaps a scan read, so no forwarding path is needed.
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && (wr.key_we || wr.stamp_we || wr.flush_one || wr.flush_all)))
        else $error("memory write during scan read");

    a_cnt_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_use_cnt >= olt_pkg::COUNTER_START)
        else $error("access counter below start value");

    a_cnt_moves_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fin_go |=> r_use_cnt == $past(r_use_cnt))
        else $error("access counter changed outside write-back");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid && $stable(r_out_data))
        else $error("pending result overwritten");

    a_hit_fwd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[37]))
        else $error("hit and forwarded both set");

endmodule

// File: rtl/olt_store.sv
// Slot storage: key and stamp memories with one read port and per-slot status flops.
module olt_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [olt_pkg::IDX_W-1:0] i_rd_idx,
    input  olt_pkg::t_wr_req         i_wr,
    output olt_pkg::t_entry          o_entry
);

    logic [olt_pkg::KEY_BITS-1:0]   r_key_mem   [olt_pkg::ENTRIES];
    logic [olt_pkg::STAMP_BITS-1:0] r_stamp_mem [olt_pkg::ENTRIES];
    olt_pkg::t_slot_st              r_status    [olt_pkg::ENTRIES];

    logic [olt_pkg::KEY_BITS-1:0]   r_rd_key;
    logic [olt_pkg::STAMP_BITS-1:0] r_rd_stamp;
    olt_pkg::t_slot_st              r_rd_st;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key_mem[i_wr.idx] <= i_wr.key;
        end
        if (i_wr.stamp_we) begin
            r_stamp_mem[i_wr.idx] <= i_wr.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_key   <= r_key_mem[i_rd_idx];
            r_rd_stamp <= r_stamp_mem[i_rd_idx];
        end
    end

    // A slot's stamp memory entry counts only while the slot is in use; the
    // never-used and flushed ranks live entirely in the status flops.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < olt_pkg::ENTRIES; i++) begin
                r_status[i] <= olt_pkg::SLOT_NEVER;
            end
            r_rd_st <= olt_pkg::SLOT_NEVER;
        end else begin
            if (i_wr.flush_all) begin
                for (int i = 0; i < olt_pkg::ENTRIES; i++) begin
                    r_status[i] <= olt_pkg::SLOT_FLUSHED;
                end
            end else if (i_wr.flush_one) begin
                r_status[i_wr.idx] <= olt_pkg::SLOT_FLUSHED;
            end else if (i_wr.stamp_we) begin
                r_status[i_wr.idx] <= olt_pkg::SLOT_USED;
            end
            if (i_rd_en) begin
                r_rd_st <= r_status[i_rd_idx];
            end
        end
    end

    always_comb begin
        o_entry.key   = r_rd_key;
        o_entry.valid = (r_rd_st == olt_pkg::SLOT_USED);
        unique case (r_rd_st)
            olt_pkg::SLOT_USED:    o_entry.stamp = r_rd_stamp;
            olt_pkg::SLOT_FLUSHED: o_entry.stamp = olt_pkg::STAMP_FLUSHED;
            default:               o_entry.stamp = olt_pkg::STAMP_NEVER;
        endcase
    end

endmodule

// File: rtl/olt_scan.sv
// Per-entry scan step: first key match and first oldest stamp over the read stream.
module olt_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic                       i_first,
    input  logic [olt_pkg::IDX_W-1:0]  i_idx,
    input  olt_pkg::t_entry            i_entry,
    input  logic [olt_pkg::KEY_BITS-1:0] i_key,
    output olt_pkg::t_scan_res         o_res
);

    logic                           r_hit;
    logic [olt_pkg::IDX_W-1:0]      r_hit_idx;
    logic [olt_pkg::STAMP_BITS-1:0] r_min_stamp;
    logic [olt_pkg::IDX_W-1:0]      r_min_idx;
    logic                           r_min_valid;
    logic [olt_pkg::KEY_BITS-1:0]   r_min_key;
    logic                           match;
    logic                           older;

    assign match = i_entry.valid && (i_entry.key == i_key);
    assign older = i_first || (i_entry.stamp < r_min_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_vld) begin
            if (i_first) begin
                r_hit <= match;
            end else if (match) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Only the first matching slot and the first minimum are kept.
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            if (match && (i_first || !r_hit)) begin
                r_hit_idx <= i_idx;
            end
            if (older) begin
                r_min_stamp <= i_entry.stamp;
                r_min_idx   <= i_idx;
                r_min_valid <= i_entry.valid;
                r_min_key   <= i_entry.key;
            end
        end
    end

    assign o_res.hit       = r_hit;
    assign o_res.hit_idx   = r_hit_idx;
    assign o_res.min_idx   = r_min_idx;
    assign o_res.min_valid = r_min_valid;
    assign o_res.min_key   = r_min_key;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the open-handle LRU table: directed and random requests against a predictor.
module tb_top;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 4000;
    localparam int TAIL_CYCLES      = 2 * olt_pkg::ENTRIES + 10;
    localparam int POOL_SIZE        = 12;
    localparam int RANDOM_PER_PHASE = 390;
    localparam int PRED_DEPTH       = 16;
    localparam int FIELD_W          = olt_pkg::FKEY_BITS;

    typedef struct packed {
        logic                          hit;
        logic [olt_pkg::SLOT_BITS-1:0] slot;
        logic                          replaced_valid;
        logic [olt_pkg::FKEY_BITS-1:0] replaced_key;
        logic                          forwarded;
        logic                          found;
    } t_lookup_result;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [olt_pkg::IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [olt_pkg::IN_USER_W-1:0]  i_s_tuser  = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [olt_pkg::OUT_DATA_W-1:0] o_m_tdata;

    open_handle_lru_table_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted table contents.
    logic [olt_pkg::KEY_BITS-1:0]   pred_keys  [olt_pkg::ENTRIES];
    logic                           pred_valid [olt_pkg::ENTRIES];
    logic [olt_pkg::STAMP_BITS-1:0] pred_stamp [olt_pkg::ENTRIES];
    logic [olt_pkg::STAMP_BITS-1:0] pred_counter;

    // Predicted results in request order; the sender writes, the checker reads.
    t_lookup_result pred_fifo [PRED_DEPTH];
    int pred_wr = 0;
    int pred_rd = 0;
    logic [olt_pkg::FKEY_BITS-1:0] key_pool[POOL_SIZE];

    int mismatches  = 0;
    int send_idle   = 0;
    int recv_stall  = 0;
    int hold_asks   = 0;
    int hold_done   = 0;
    int hold_left   = 0;
    int quiet_count = 0;

    function automatic logic [olt_pkg::STAMP_BITS-1:0] take_stamp();
        logic [olt_pkg::STAMP_BITS-1:0] s;
        s = pred_counter;
        if (pred_counter != olt_pkg::COUNTER_MAX)
            pred_counter = pred_counter + 1'b1;
        return s;
    endfunction

    function automatic t_lookup_result table_predict(logic [1:0] req,
                                                     logic [olt_pkg::FKEY_BITS-1:0] key,
                                                     logic open_ok);
        t_lookup_result r;
        int idx;
        int victim;
        logic [olt_pkg::STAMP_BITS-1:0] oldest;
        r = '0;
        idx = -1;
        for (int i = 0; i < olt_pkg::ENTRIES; i++)
            if (idx < 0 && pred_valid[i] && pred_keys[i] == key)
                idx = i;
        case (req)
            olt_pkg::REQ_ACCESS: begin
                if (idx >= 0) begin
                    r.hit = 1'b1;
                    r.slot = olt_pkg::SLOT_BITS'(idx);
                    pred_stamp[idx] = take_stamp();
                end else begin
                    victim = 0;
                    oldest = pred_stamp[0];
                    for (int i = 1; i < olt_pkg::ENTRIES; i++)
                        if (pred_stamp[i] < oldest) begin
                            oldest = pred_stamp[i];
                            victim = i;
                        end
                    if (open_ok) begin
                        r.slot = olt_pkg::SLOT_BITS'(victim);
                        if (pred_valid[victim]) begin
                            r.replaced_valid = 1'b1;
                            r.replaced_key = pred_keys[victim];
                        end
                        pred_keys[victim] = key;
                        pred_valid[victim] = 1'b1;
                        pred_stamp[victim] = take_stamp();
                    end else begin
                        r.forwarded = 1'b1;
                    end
                end
            end
            olt_pkg::REQ_FLUSH_ONE: begin
                if (idx >= 0) begin
                    r.found = 1'b1;
                    r.slot = olt_pkg::SLOT_BITS'(idx);
                    pred_valid[idx] = 1'b0;
                    pred_stamp[idx] = olt_pkg::STAMP_FLUSHED;
                end
            end
            olt_pkg::REQ_FLUSH_ALL: begin
                for (int i = 0; i < olt_pkg::ENTRIES; i++) begin
                    pred_valid[i] = 1'b0;
                    pred_stamp[i] = olt_pkg::STAMP_FLUSHED;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offers one request, waits for it to be taken and records what it should produce.
    task automatic send_request(logic [1:0] req, logic [olt_pkg::FKEY_BITS-1:0] key,
                                logic open_ok);
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {{(olt_pkg::IN_DATA_W - olt_pkg::FKEY_BITS - 1){1'b0}}, open_ok, key};
        do @(posedge i_clk); while (!o_s_tready);
        pred_fifo[pred_wr % PRED_DEPTH] = table_predict(req, key, open_ok);
        pred_wr++;
    endtask

    task automatic send_random_request();
        int pick;
        logic [olt_pkg::FKEY_BITS-1:0] key;
        logic [1:0] req;
        pick = $urandom_range(99);
        if (pick < 78)
            req = olt_pkg::REQ_ACCESS;
        else if (pick < 94)
            req = olt_pkg::REQ_FLUSH_ONE;
        else if (pick < 97)
            req = olt_pkg::REQ_FLUSH_ALL;
        else
            req = REQ_UNUSED;
        // Mostly keys from a small pool, so that hits, evictions and flush matches are common.
        if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            key = $urandom;
        send_request(req, key, $urandom_range(9) != 0);
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (pred_wr != pred_rd)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_idle = 0;
        recv_stall = 0;
        send_request(olt_pkg::REQ_FLUSH_ONE, 32'h0000_0000, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'hFFFF_FFFF, 1'b0);
        send_request(olt_pkg::REQ_ACCESS, 32'h0000_0000, 1'b1);
        // A flushed slot must be passed over while never-used ones remain.
        send_request(olt_pkg::REQ_FLUSH_ONE, 32'h0000_0000, 1'b0);
        send_request(olt_pkg::REQ_ACCESS, 32'h0000_0000, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'hFFFF_FFFF, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h0000_0000, 1'b0);
        send_request(olt_pkg::REQ_ACCESS, 32'hA5A5_A5A5, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h5A5A_5A5A, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h0000_0001, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h8000_0000, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h1234_5678, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'hDEAD_BEEF, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'hCAFE_F00D, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h7654_3210, 1'b1);
        send_request(olt_pkg::REQ_FLUSH_ONE, 32'hA5A5_A5A5, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h0F0F_0F0F, 1'b1);
        send_request(olt_pkg::REQ_FLUSH_ONE, 32'hA5A5_A5A5, 1'b0);
        send_request(REQ_UNUSED, 32'h1234_5678, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h1234_5678, 1'b0);
        send_request(olt_pkg::REQ_FLUSH_ALL, 32'hFFFF_FFFF, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h0000_0000, 1'b1);
        send_request(olt_pkg::REQ_FLUSH_ONE, 32'h0000_0000, 1'b1);
        send_request(olt_pkg::REQ_ACCESS, 32'h7FFF_FFFF, 1'b0);
        send_request(olt_pkg::REQ_FLUSH_ALL, 32'h0000_0000, 1'b0);
        wait_all_results();
    endtask

    task automatic test_random(int idle_pct, int stall_pct);
        send_idle = idle_pct;
        recv_stall = stall_pct;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_random_request();
        wait_all_results();
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the input stalls.
    task automatic test_output_backpressure();
        send_idle = 0;
        recv_stall = 0;
        hold_asks <= hold_asks + 1;
        for (int n = 0; n < 24; n++)
            send_random_request();
        wait_all_results();
    endtask

    always @(posedge i_clk) begin
        if (hold_asks != hold_done) begin
            hold_done <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pred_wr == pred_rd) begin
                $error("result with nothing expected: tdata %0h", o_m_tdata);
                mismatches++;
            end else begin
                want = pred_fifo[pred_rd % PRED_DEPTH];
                pred_rd++;
                check_field("hit", FIELD_W'(want.hit), FIELD_W'(o_m_tdata[0]));
                check_field("slot", FIELD_W'(want.slot), FIELD_W'(o_m_tdata[3:1]));
                check_field("replaced_valid", FIELD_W'(want.replaced_valid),
                            FIELD_W'(o_m_tdata[4]));
                check_field("replaced_key", want.replaced_key, o_m_tdata[36:5]);
                check_field("forwarded", FIELD_W'(want.forwarded), FIELD_W'(o_m_tdata[37]));
                check_field("found", FIELD_W'(want.found), FIELD_W'(o_m_tdata[38]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            quiet_count <= 0;
        end else if (quiet_count >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        for (int i = 0; i < olt_pkg::ENTRIES; i++) begin
            pred_keys[i]  = '0;
            pred_valid[i] = 1'b0;
            pred_stamp[i] = olt_pkg::STAMP_NEVER;
        end
        pred_counter = olt_pkg::COUNTER_START;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(0, 0);
        test_random(72, 0);
        test_random(0, 72);
        test_random(20, 20);
        test_output_backpressure();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pred_wr == pred_rd) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/olt_pkg.sv
rtl/olt_store.sv
rtl/olt_scan.sv
rtl/open_handle_lru_table_top.sv
tb/sv/tb_top.sv
